/* rtl/rqs_pkg.sv */
// Shared constants, codes and types of the ready queue CPU scheduler.
`timescale 1ns / 1ps

package rqs_pkg;

    localparam int NUM_CPUS    = 16;
    localparam int QUEUE_DEPTH = 64;

    localparam int CPU_W      = $clog2(NUM_CPUS);
    localparam int CNT_W      = $clog2(NUM_CPUS + 1);
    localparam int QA_W       = $clog2(QUEUE_DEPTH);
    localparam int QC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OP_W       = 3;
    localparam int CPU_FLD_W  = 4;
    localparam int ID_W       = 6;
    localparam int PRIO_W     = 5;
    localparam int SLICE_W    = 8;
    localparam int ACT_W      = 5;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [PRIO_W-1:0] PRIO_CAP = PRIO_W'(20);

    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_MODE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SLICE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = CFG_IDX_W'(2);

    typedef enum logic [OP_W-1:0] {
        OP_WAKE      = 3'd0,
        OP_PREEMPT   = 3'd1,
        OP_YIELD     = 3'd2,
        OP_TERMINATE = 3'd3,
        OP_IDLE      = 3'd4
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_IDLE     = 2'd1,
        KIND_PREEMPT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic             we;
        logic [CPU_W-1:0] waddr;
        t_q_entry         wdata;
        logic [CPU_W-1:0] raddr;
    } t_tbl_req;

    typedef struct packed {
        t_kind                kind;
        logic [CPU_FLD_W-1:0] cpu;
        logic [ID_W-1:0]      id;
        logic [PRIO_W-1:0]    prio;
        logic [SLICE_W-1:0]   slice;
        logic                 ovf;
    } t_result;

endpackage

/* rtl/rqs_in_if.sv */
// Event channel into the scheduler: valid, ready and the event fields.
`timescale 1ns / 1ps

interface rqs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [3:0] cpu_index;
    logic [5:0] process_id;
    logic [4:0] process_priority;

    modport source (output valid, output opcode, output cpu_index, output process_id,
                    output process_priority, input ready);
    modport sink (input valid, input opcode, input cpu_index, input process_id,
                  input process_priority, output ready);
endinterface

/* rtl/rqs_out_if.sv */
// Result channel out of the scheduler: valid, ready and the result fields.
`timescale 1ns / 1ps

interface rqs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] target_cpu;
    logic [5:0] out_process_id;
    logic [4:0] out_priority;
    logic [7:0] slice_length;
    logic       queue_overflow;

    modport source (output valid, output kind, output target_cpu, output out_process_id,
                    output out_priority, output slice_length, output queue_overflow,
                    input ready);
    modport sink (input valid, input kind, input target_cpu, input out_process_id,
                  input out_priority, input slice_length, input queue_overflow,
                  output ready);
endinterface

/* rtl/rqs_queue.sv */
// Ready queue: a FIFO in a synchronous memory with head, tail and fill count.
`timescale 1ns / 1ps

module rqs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rqs_pkg::t_q_entry i_push_data,
    input  logic              i_pop,
    output rqs_pkg::t_q_entry o_pop_data,
    output rqs_pkg::t_q_stat  o_stat
);
    import rqs_pkg::*;

    t_q_entry        r_mem [QUEUE_DEPTH];
    t_q_entry        r_rd_data;
    logic [QA_W-1:0] r_head;
    logic [QA_W-1:0] r_tail;
    logic [QC_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pop_data   = r_rd_data;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QC_W'(QUEUE_DEPTH));

endmodule

/* rtl/rqs_cpu_table.sv */
// Per-CPU table of the running process id and priority in a synchronous memory.
`timescale 1ns / 1ps

module rqs_cpu_table (
    input  logic              i_clk,
    input  rqs_pkg::t_tbl_req i_req,
    output rqs_pkg::t_q_entry o_rd_data
);
    import rqs_pkg::*;

    t_q_entry r_mem [NUM_CPUS];
    t_q_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ready_queue_cpu_scheduler_unit.sv */
// Top level of the ready queue CPU scheduler: event sequencer, CPU flags and result register.
// A dispatch passes states DISP, POP and RESULT; a preempt of a busy CPU adds PRE_RD first.
// A priority wake-up scan reads one CPU table entry per cycle, over the active CPUs.
// Throughput: one event at a time; the next event is taken once the sequencer is back in idle.
// Synchronous active-low reset empties the queue and clears all busy and parked flags.
`timescale 1ns / 1ps

module ready_queue_cpu_scheduler_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    rqs_in_if.sink                             i_in,
    rqs_out_if.source                          o_out
);
    import rqs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE_RD,
        ST_DISP,
        ST_POP,
        ST_SCAN,
        ST_RESULT
    } t_state;

    t_state              r_state, n_state;
    logic [CPU_W-1:0]    r_cpu, n_cpu;
    logic [PRIO_W-1:0]   r_wprio, n_wprio;
    logic                r_ovf, n_ovf;
    logic [CNT_W-1:0]    r_scan, n_scan;
    logic                r_rd_vld, n_rd_vld;
    logic [CPU_W-1:0]    r_rd_idx, n_rd_idx;
    logic [PRIO_W-1:0]   r_worst, n_worst;
    logic [CPU_W-1:0]    r_widx, n_widx;
    logic [NUM_CPUS-1:0] r_busy, n_busy;
    logic [NUM_CPUS-1:0] r_parked, n_parked;
    t_result             r_res, n_res;
    logic                r_out_vld, n_out_vld;
    t_result             r_out, n_out;

    logic                r_prio_mode;
    logic [SLICE_W-1:0]  r_slice;
    logic [ACT_W-1:0]    r_active;

    logic                w_in_acc;
    logic [CPU_W-1:0]    w_in_cpu;
    logic                w_cpu_ok;
    logic [CNT_W-1:0]    w_lim;
    logic [NUM_CPUS-1:0] w_range;
    logic                w_park_hit;
    logic [CPU_W-1:0]    w_park_idx;
    logic                w_any_free;
    logic [PRIO_W-1:0]   w_pprio;

    logic                q_push;
    t_q_entry            q_push_data;
    logic                q_pop;
    t_q_entry            q_pop_data;
    t_q_stat             q_stat;
    t_tbl_req            tbl_req;
    t_q_entry            tbl_rd;

    rqs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_stat      (q_stat)
    );

    rqs_cpu_table u_cpu_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_mode <= 1'b0;
            r_slice     <= '0;
            r_active    <= ACT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRIO_MODE:   r_prio_mode <= i_cfg_data[0];
                CFG_TIME_SLICE:  r_slice     <= i_cfg_data[SLICE_W-1:0];
                CFG_ACTIVE_CPUS: r_active    <= i_cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_in_cpu   = CPU_W'(i_in.cpu_index);
    assign w_cpu_ok   = (32'(i_in.cpu_index) < NUM_CPUS);
    assign w_lim      = (32'(r_active) > NUM_CPUS) ? CNT_W'(NUM_CPUS) : CNT_W'(r_active);
    assign w_pprio    = (q_pop_data.prio < PRIO_CAP) ? q_pop_data.prio + 1'b1 : q_pop_data.prio;

    always_comb begin
        w_park_hit = 1'b0;
        w_park_idx = '0;
        for (int i = 0; i < NUM_CPUS; i++) begin
            w_range[i] = (i < 32'(w_lim));
        end
        for (int i = NUM_CPUS - 1; i >= 0; i--) begin
            if (r_parked[i] && w_range[i]) begin
                w_park_hit = 1'b1;
                w_park_idx = CPU_W'(i);
            end
        end
        w_any_free = |(~r_busy & w_range);
    end

    always_comb begin
        n_state   = r_state;
        n_cpu     = r_cpu;
        n_wprio   = r_wprio;
        n_ovf     = r_ovf;
        n_scan    = r_scan;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_worst   = r_worst;
        n_widx    = r_widx;
        n_busy    = r_busy;
        n_parked  = r_parked;
        n_res     = r_res;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out     = r_out;

        q_push           = 1'b0;
        q_push_data.id   = i_in.process_id;
        q_push_data.prio = i_in.process_priority;
        q_pop            = 1'b0;

        tbl_req.we    = 1'b0;
        tbl_req.waddr = r_cpu;
        tbl_req.wdata = '{id: q_pop_data.id, prio: w_pprio};
        tbl_req.raddr = (r_state == ST_SCAN) ? r_scan[CPU_W-1:0] : w_in_cpu;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cpu   = w_in_cpu;
                    n_wprio = i_in.process_priority;
                    n_ovf   = 1'b0;
                    if (i_in.opcode == OP_WAKE) begin
                        if (q_stat.full) begin
                            n_res     = '0;
                            n_res.ovf = 1'b1;
                            n_state   = ST_RESULT;
                        end else begin
                            q_push = 1'b1;
                            if (w_park_hit) begin
                                n_cpu   = w_park_idx;
                                n_state = ST_DISP;
                            end else if (r_prio_mode && !w_any_free) begin
                                n_scan   = '0;
                                n_rd_vld = 1'b0;
                                n_worst  = '0;
                                n_widx   = '0;
                                n_state  = ST_SCAN;
                            end
                        end
                    end else if (w_cpu_ok) begin
                        priority if (i_in.opcode == OP_PREEMPT) begin
                            n_state = r_busy[w_in_cpu] ? ST_PRE_RD : ST_DISP;
                        end else if (i_in.opcode == OP_YIELD ||
                                     i_in.opcode == OP_TERMINATE) begin
                            n_busy[w_in_cpu] = 1'b0;
                            n_state          = ST_DISP;
                        end else if (i_in.opcode == OP_IDLE) begin
                            if (q_stat.empty) begin
                                n_busy[w_in_cpu]   = 1'b0;
                                n_parked[w_in_cpu] = 1'b1;
                            end else begin
                                n_state = ST_DISP;
                            end
                        end else begin
                        end
                    end
                end
            end
            ST_PRE_RD: begin
                if (q_stat.full) begin
                    n_ovf = 1'b1;
                end else begin
                    q_push      = 1'b1;
                    q_push_data = tbl_rd;
                end
                n_state = ST_DISP;
            end
            ST_DISP: begin
                n_parked[r_cpu] = 1'b0;
                if (q_stat.empty) begin
                    n_busy[r_cpu] = 1'b0;
                    n_res.kind    = KIND_IDLE;
                    n_res.cpu     = CPU_FLD_W'(r_cpu);
                    n_res.id      = '0;
                    n_res.prio    = '0;
                    n_res.slice   = r_slice;
                    n_res.ovf     = r_ovf;
                    n_state       = ST_RESULT;
                end else begin
                    q_pop   = 1'b1;
                    n_state = ST_POP;
                end
            end
            ST_POP: begin
                n_busy[r_cpu] = 1'b1;
                tbl_req.we    = 1'b1;
                n_res.kind    = KIND_DISPATCH;
                n_res.cpu     = CPU_FLD_W'(r_cpu);
                n_res.id      = q_pop_data.id;
                n_res.prio    = w_pprio;
                n_res.slice   = r_slice;
                n_res.ovf     = r_ovf;
                n_state       = ST_RESULT;
            end
            ST_SCAN: begin
                if (r_rd_vld && tbl_rd.prio > r_worst) begin
                    n_worst = tbl_rd.prio;
                    n_widx  = r_rd_idx;
                end
                if (r_scan < w_lim) begin
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_scan[CPU_W-1:0];
                    n_scan   = r_scan + 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld) begin
                        if (r_worst > r_wprio) begin
                            n_res      = '0;
                            n_res.kind = KIND_PREEMPT;
                            n_res.cpu  = CPU_FLD_W'(r_widx);
                            n_state    = ST_RESULT;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_busy    <= '0;
            r_parked  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= n_rd_vld;
            r_busy    <= n_busy;
            r_parked  <= n_parked;
            r_out_vld <= n_out_vld;
        end
        r_cpu    <= n_cpu;
        r_wprio  <= n_wprio;
        r_ovf    <= n_ovf;
        r_scan   <= n_scan;
        r_rd_idx <= n_rd_idx;
        r_worst  <= n_worst;
        r_widx   <= n_widx;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.kind           = KIND_W'(r_out.kind);
    assign o_out.target_cpu     = r_out.cpu;
    assign o_out.out_process_id = r_out.id;
    assign o_out.out_priority   = r_out.prio;
    assign o_out.slice_length   = r_out.slice;
    assign o_out.queue_overflow = r_out.ovf;

    a_busy_parked_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy & r_parked) == '0)
        else $error("A CPU is both busy and parked.");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty && !q_push)
        else $error("Ready queue popped while empty or during a push.");

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld ##1 r_out_vld |-> $past(r_state == ST_RESULT))
        else $error("Result register loaded outside the result state.");

endmodule

/* verif/tb_ready_queue_cpu_scheduler_unit.sv */
// Testbench for the ready queue CPU scheduler: directed table and random events checked by a predictor.
`timescale 1ns / 1ps

module tb_ready_queue_cpu_scheduler_unit;
    import rqs_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 7;
    localparam int DIR_N         = 20;
    localparam int DIR_SPLIT     = 12;
    localparam int NUM_PHASES    = 6;
    localparam int FLOOD_PHASE   = 2;
    localparam int CALM_PHASE    = 3;
    localparam int FLOOD_ITEMS   = 100;
    localparam int FLOOD_WAKES   = 80;
    localparam int PHASE_ITEMS   = 85;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;

    typedef struct packed {
        logic    pinned;
        logic    has;
        t_result res;
    } t_pin;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [CPU_FLD_W-1:0] cpu;
        logic [ID_W-1:0]      pid;
        logic [PRIO_W-1:0]    prio;
        t_pin                 pin;
    } t_row;

    localparam t_pin PIN_FREE = '0;
    localparam t_pin PIN_NONE = '{pinned: 1'b1, has: 1'b0, res: '0};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    t_pin pin_tag;

    rqs_in_if ev_ch ();
    rqs_out_if res_ch ();

    ready_queue_cpu_scheduler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (ev_ch),
        .o_out       (res_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    logic                 mode_cfg   = 1'b0;
    logic [SLICE_W-1:0]   slice_cfg  = '0;
    logic [ACT_W-1:0]     active_cfg = 5'd1;
    t_q_entry             ready_fifo[$];
    bit                   busy_flag [NUM_CPUS];
    bit                   parked_flag [NUM_CPUS];
    logic [ID_W-1:0]      run_id [NUM_CPUS];
    logic [PRIO_W-1:0]    run_prio [NUM_CPUS];
    t_result              expected_results[$];

    t_row dir_rows [DIR_N];
    bit   calm = 1'b0;
    int   mismatch_cnt = 0;
    int   events_taken = 0;
    int   results_seen = 0;
    int   drops_seen = 0;
    int   cycle_cnt = 0;

    function automatic t_result dispatch_to(input int c, input logic ovf);
        t_q_entry e;
        t_result r;
        r = '0;
        r.cpu = 4'(c);
        r.slice = slice_cfg;
        r.ovf = ovf;
        parked_flag[c] = 1'b0;
        if (ready_fifo.size() == 0) begin
            busy_flag[c] = 1'b0;
            r.kind = KIND_IDLE;
        end else begin
            e = ready_fifo.pop_front();
            if (e.prio < PRIO_CAP) begin
                e.prio = e.prio + 5'd1;
            end
            busy_flag[c] = 1'b1;
            run_id[c] = e.id;
            run_prio[c] = e.prio;
            r.kind = KIND_DISPATCH;
            r.id = e.id;
            r.prio = e.prio;
        end
        return r;
    endfunction

    function automatic bit schedule_event(input logic [OP_W-1:0] ev_op,
                                          input logic [CPU_FLD_W-1:0] ev_cpu,
                                          input logic [ID_W-1:0] ev_pid,
                                          input logic [PRIO_W-1:0] ev_prio,
                                          output t_result res);
        int n;
        int worst_idx;
        int c;
        logic [PRIO_W-1:0] worst;
        logic ovf;
        res = '0;
        c = int'(ev_cpu);
        n = (int'(active_cfg) > NUM_CPUS) ? NUM_CPUS : int'(active_cfg);
        case (ev_op)
            OP_WAKE: begin
                if (ready_fifo.size() >= QUEUE_DEPTH) begin
                    res.ovf = 1'b1;
                    return 1'b1;
                end
                ready_fifo.push_back('{id: ev_pid, prio: ev_prio});
                for (int i = 0; i < n; i++) begin
                    if (parked_flag[i]) begin
                        res = dispatch_to(i, 1'b0);
                        return 1'b1;
                    end
                end
                if (mode_cfg) begin
                    worst = '0;
                    worst_idx = 0;
                    for (int i = 0; i < n; i++) begin
                        if (!busy_flag[i]) begin
                            return 1'b0;
                        end
                        if (run_prio[i] > worst) begin
                            worst = run_prio[i];
                            worst_idx = i;
                        end
                    end
                    if (worst > ev_prio) begin
                        res.kind = KIND_PREEMPT;
                        res.cpu = 4'(worst_idx);
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            OP_PREEMPT: begin
                ovf = 1'b0;
                if (busy_flag[c]) begin
                    if (ready_fifo.size() >= QUEUE_DEPTH) begin
                        ovf = 1'b1;
                    end else begin
                        ready_fifo.push_back('{id: run_id[c], prio: run_prio[c]});
                    end
                end
                res = dispatch_to(c, ovf);
                return 1'b1;
            end
            OP_YIELD, OP_TERMINATE: begin
                busy_flag[c] = 1'b0;
                res = dispatch_to(c, 1'b0);
                return 1'b1;
            end
            OP_IDLE: begin
                if (ready_fifo.size() == 0) begin
                    busy_flag[c] = 1'b0;
                    parked_flag[c] = 1'b1;
                    return 1'b0;
                end
                res = dispatch_to(c, 1'b0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", fname, want, seen);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        bit has;
        t_result res;
        t_result want;
        if (res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (res_ch.queue_overflow) begin
                drops_seen++;
            end
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d cpu %0d", res_ch.kind, res_ch.target_cpu);
                mismatch_cnt++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, res_ch.kind);
                check_field("target_cpu", want.cpu, res_ch.target_cpu);
                check_field("out_process_id", want.id, res_ch.out_process_id);
                check_field("out_priority", want.prio, res_ch.out_priority);
                check_field("slice_length", want.slice, res_ch.slice_length);
                check_field("queue_overflow", want.ovf, res_ch.queue_overflow);
            end
        end
        if (ev_ch.valid && ev_ch.ready) begin
            events_taken++;
            has = schedule_event(ev_ch.opcode, ev_ch.cpu_index, ev_ch.process_id,
                                 ev_ch.process_priority, res);
            if (pin_tag.pinned) begin
                has = pin_tag.has;
                res = pin_tag.res;
            end
            if (has) begin
                expected_results.push_back(res);
            end
        end
    end

    always @(posedge i_clk) begin
        res_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out with %0d results still expected.", expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic issue_event(input logic [OP_W-1:0] op, input logic [CPU_FLD_W-1:0] c,
                               input logic [ID_W-1:0] pid, input logic [PRIO_W-1:0] pr,
                               input t_pin pin);
        int gap;
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            ev_ch.valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge i_clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.opcode <= op;
        ev_ch.cpu_index <= c;
        ev_ch.process_id <= pid;
        ev_ch.process_priority <= pr;
        pin_tag <= pin;
        do @(posedge i_clk); while (!ev_ch.ready);
    endtask

    task automatic settle_block();
        ev_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic mode, input logic [SLICE_W-1:0] slice,
                                input logic [ACT_W-1:0] act);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_PRIO_MODE;
        i_cfg_data <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_TIME_SLICE;
        i_cfg_data <= slice;
        @(posedge i_clk);
        i_cfg_index <= CFG_ACTIVE_CPUS;
        i_cfg_data <= CFG_DATA_W'(act);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_cfg = mode;
        slice_cfg = slice;
        active_cfg = act;
    endtask

    task automatic random_event(input bit flood, input int k);
        int r;
        int top;
        logic [OP_W-1:0] op;
        logic [CPU_FLD_W-1:0] c;
        top = int'(active_cfg) - 1;
        r = $urandom_range(0, 99);
        if (flood) begin
            op = (k < FLOOD_WAKES || r < 80) ? OP_WAKE : OP_PREEMPT;
        end else if (r < 35) begin
            op = OP_WAKE;
        end else if (r < 50) begin
            op = OP_PREEMPT;
        end else if (r < 60) begin
            op = OP_YIELD;
        end else if (r < 70) begin
            op = OP_TERMINATE;
        end else if (r < 95) begin
            op = OP_IDLE;
        end else begin
            op = OP_UNDEFINED - 3'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 99) < 80) begin
            c = 4'($urandom_range(0, top));
        end else begin
            c = 4'($urandom);
        end
        issue_event(op, c, 6'($urandom), 5'($urandom), PIN_FREE);
    endtask

    initial begin
        logic mode;
        logic [SLICE_W-1:0] slice;
        logic [ACT_W-1:0] act;
        int n_items;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        ev_ch.valid <= 1'b0;
        ev_ch.opcode <= '0;
        ev_ch.cpu_index <= '0;
        ev_ch.process_id <= '0;
        ev_ch.process_priority <= '0;
        pin_tag <= PIN_FREE;

        dir_rows[0]  = '{OP_IDLE, 4'd0, 6'd0, 5'd0, PIN_NONE};
        dir_rows[1]  = '{OP_WAKE, 4'd0, 6'd63, 5'd31,
                         '{1'b1, 1'b1, '{KIND_DISPATCH, 4'd0, 6'd63, 5'd31, 8'd0, 1'b0}}};
        dir_rows[2]  = '{OP_WAKE, 4'd0, 6'd0, 5'd0, PIN_NONE};
        dir_rows[3]  = '{OP_PREEMPT, 4'd0, 6'd0, 5'd0, PIN_FREE};
        dir_rows[4]  = '{OP_YIELD, 4'd15, 6'd0, 5'd0, PIN_FREE};
        dir_rows[5]  = '{OP_TERMINATE, 4'd15, 6'd0, 5'd0,
                         '{1'b1, 1'b1, '{KIND_IDLE, 4'd15, 6'd0, 5'd0, 8'd0, 1'b0}}};
        dir_rows[6]  = '{OP_PREEMPT, 4'd7, 6'd0, 5'd0,
                         '{1'b1, 1'b1, '{KIND_IDLE, 4'd7, 6'd0, 5'd0, 8'd0, 1'b0}}};
        dir_rows[7]  = '{OP_UNDEFINED, 4'd0, 6'd0, 5'd0, PIN_NONE};
        dir_rows[8]  = '{OP_WAKE, 4'd0, 6'd19, 5'd19, PIN_FREE};
        dir_rows[9]  = '{OP_IDLE, 4'd3, 6'd0, 5'd0, PIN_FREE};
        dir_rows[10] = '{OP_WAKE, 4'd0, 6'd20, 5'd20, PIN_FREE};
        dir_rows[11] = '{OP_IDLE, 4'd4, 6'd0, 5'd0, PIN_FREE};
        dir_rows[12] = '{OP_IDLE, 4'd9, 6'd0, 5'd0, PIN_NONE};
        dir_rows[13] = '{OP_WAKE, 4'd0, 6'd5, 5'd3, PIN_FREE};
        dir_rows[14] = '{OP_YIELD, 4'd1, 6'd0, 5'd0, PIN_FREE};
        dir_rows[15] = '{OP_WAKE, 4'd0, 6'd6, 5'd2, PIN_FREE};
        dir_rows[16] = '{OP_PREEMPT, 4'd1, 6'd0, 5'd0, PIN_FREE};
        dir_rows[17] = '{OP_WAKE, 4'd0, 6'd7, 5'd31, PIN_FREE};
        dir_rows[18] = '{OP_YIELD, 4'd0, 6'd0, 5'd0, PIN_FREE};
        dir_rows[19] = '{OP_TERMINATE, 4'd1, 6'd0, 5'd0, PIN_FREE};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first rows run on the reset register values; the rest use priority mode.
        for (int k = 0; k < DIR_N; k++) begin
            if (k == DIR_SPLIT) begin
                settle_block();
                apply_config(1'b1, 8'd255, 5'd2);
            end
            issue_event(dir_rows[k].op, dir_rows[k].cpu, dir_rows[k].pid, dir_rows[k].prio,
                        dir_rows[k].pin);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle_block();
            mode = 1'($urandom);
            slice = 8'($urandom);
            act = 5'($urandom_range(1, NUM_CPUS));
            case (ph)
                0: begin
                    mode = 1'b1;
                    slice = 8'd255;
                    act = 5'd1;
                end
                1: begin
                    mode = 1'b0;
                    slice = 8'd0;
                    act = 5'(NUM_CPUS);
                end
                FLOOD_PHASE: begin
                    mode = 1'b0;
                    act = 5'($urandom_range(1, 4));
                end
                CALM_PHASE: begin
                    mode = 1'b1;
                    act = 5'(NUM_CPUS);
                end
                4: begin
                    mode = 1'b1;
                    act = 5'($urandom_range(2, 6));
                end
                default: ;
            endcase
            apply_config(mode, slice, act);
            calm = (ph == CALM_PHASE);
            n_items = (ph == FLOOD_PHASE) ? FLOOD_ITEMS : PHASE_ITEMS;
            for (int k = 0; k < n_items; k++) begin
                random_event(ph == FLOOD_PHASE, k);
            end
        end
        calm = 1'b0;
        settle_block();

        $display("Ran %0d events (%0d directed) over %0d register settings.",
                 events_taken, DIR_N, NUM_PHASES + 2);
        $display("Compared %0d results, %0d of them with a dropped push.",
                 results_seen, drops_seen);
        if (mismatch_cnt == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
